>>> src/upe_pkg.sv
// upe_pkg: shared types, character constants and the category table for the url part escaper
// no dependencies; used by the interfaces, upe_classify and url_part_escaper
`default_nettype none
package upe_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MASK_W  = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = MASK_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CATEGORY_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_PERCENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASCII_ONLY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NON_ASCII     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_COPY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_COLON  = 3'd5;

  // characters and bounds
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3a;
  localparam logic [BYTE_W-1:0] CH_PIPE    = 8'h7c;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL     = 8'h7f;

  // position inside an escape triple
  localparam int unsigned PH_W = 2;
  localparam logic [PH_W-1:0] PH_PCT = 2'd0;
  localparam logic [PH_W-1:0] PH_HI  = 2'd1;
  localparam logic [PH_W-1:0] PH_LO  = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] category_mask;
    logic              force_percent;
    logic              ascii_only_mode;
    logic              non_ascii_only_mode;
    logic              always_copy;
    logic              escape_colon;
  } upe_cfg_t;

  localparam logic [MASK_W-1:0] CAT_TABLE [128] = '{
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd1023, 10'd0, 10'd512, 10'd1023, 10'd0, 10'd1023, 10'd0,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd953, 10'd784,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1008, 10'd1008, 10'd0, 10'd1008, 10'd0, 10'd768,
    10'd1008, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd896, 10'd0, 10'd896, 10'd1023,
    10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd896, 10'd1012, 10'd896, 10'd1023, 10'd0
  };

  // upper-case hex digit of a nibble
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> src/upe_if.sv
// upe_in_if / upe_out_if: valid/ready channels carrying input and result items
// depends on upe_pkg
`default_nettype none
interface upe_in_if;
  logic                       valid;
  logic                       ready;
  logic [upe_pkg::BYTE_W-1:0] in_byte;
  logic                       part_last;

  modport source (output valid, output in_byte, output part_last, input ready);
  modport sink (input valid, input in_byte, input part_last, output ready);
endinterface

interface upe_out_if;
  logic                       valid;
  logic                       ready;
  logic [upe_pkg::BYTE_W-1:0] out_byte;
  logic                       run_last;
  logic                       part_end;
  logic                       rewritten;

  modport source (output valid, output out_byte, output run_last, output part_end,
                  output rewritten, input ready);
  modport sink (input valid, input out_byte, input run_last, input part_end,
                input rewritten, output ready);
endinterface
`default_nettype wire

>>> src/upe_classify.sv
// upe_classify: decides whether one byte passes or must be percent-escaped
// depends on upe_pkg (category table, character constants, config struct)
`default_nettype none
module upe_classify (
  input  wire logic [upe_pkg::BYTE_W-1:0] byte_i,
  input  wire upe_pkg::upe_cfg_t          cfg_i,
  input  wire logic                       prev_non_ascii_i,
  output logic                            esc_o
);

  logic [upe_pkg::MASK_W-1:0] tab;
  logic                       hi_byte;
  logic                       ok;
  logic                       pass;

  always_comb begin
    hi_byte = byte_i[upe_pkg::BYTE_W-1];
    tab     = hi_byte ? '0 : upe_pkg::CAT_TABLE[byte_i[upe_pkg::BYTE_W-2:0]];
    ok = ((tab & cfg_i.category_mask) != '0)
         || (byte_i == upe_pkg::CH_PERCENT && !cfg_i.force_percent)
         || (hi_byte && cfg_i.ascii_only_mode)
         || (byte_i > upe_pkg::CH_SPACE && byte_i < upe_pkg::CH_DEL
             && cfg_i.non_ascii_only_mode);
    pass = ok
           && !(byte_i == upe_pkg::CH_COLON && cfg_i.escape_colon)
           && !(prev_non_ascii_i && byte_i == upe_pkg::CH_PIPE && !cfg_i.ascii_only_mode);
    esc_o = !pass;
  end

endmodule
`default_nettype wire

>>> src/url_part_escaper.sv
// url_part_escaper: percent-encodes the bytes of a url part, one byte per item
// path: an accepted byte is registered in the decision stage and then in the output register
// throughput: one output byte per cycle while out_ch.ready holds, set by the single output register;
// a passed byte yields one output byte, an escaped byte three (percent sign and two hex digits)
// reset (rst_n low, synchronous): config registers, part state and the valid flags of both stages cleared
// depends on upe_pkg, upe_if, upe_classify
`default_nettype none
module url_part_escaper (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  upe_in_if.sink                              in_ch,
  upe_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [upe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [upe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  upe_pkg::upe_cfg_t cfg_r;

  logic prev_non_ascii_r;
  logic escaped_any_r;

  // decision stage
  logic                       a_valid_r;
  logic [upe_pkg::PH_W-1:0]   a_phase_r;
  logic [upe_pkg::BYTE_W-1:0] a_byte_r;
  logic                       a_esc_r;
  logic                       a_last_r;
  logic                       a_rw_r;

  // output stage
  logic                       b_valid_r;
  logic [upe_pkg::BYTE_W-1:0] b_byte_r;
  logic                       b_run_last_r;
  logic                       b_part_end_r;
  logic                       b_rewritten_r;

  logic                       esc;
  logic                       acc;
  logic                       a_final;
  logic                       b_load;
  logic                       a_adv;
  logic [upe_pkg::BYTE_W-1:0] a_out_byte;

  upe_classify u_classify (
    .byte_i           (in_ch.in_byte),
    .cfg_i            (cfg_r),
    .prev_non_ascii_i (prev_non_ascii_r),
    .esc_o            (esc)
  );

  assign a_final     = !a_esc_r || (a_phase_r == upe_pkg::PH_LO);
  assign b_load      = !b_valid_r || out_ch.ready;
  assign a_adv       = a_valid_r && b_load;
  assign in_ch.ready = !a_valid_r || (a_final && b_load);
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    if (!a_esc_r) begin
      a_out_byte = a_byte_r;
    end else begin
      case (a_phase_r)
        upe_pkg::PH_PCT: a_out_byte = upe_pkg::CH_PERCENT;
        upe_pkg::PH_HI:  a_out_byte = upe_pkg::hex_digit(a_byte_r[7:4]);
        default:         a_out_byte = upe_pkg::hex_digit(a_byte_r[3:0]);
      endcase
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r            <= '0;
      prev_non_ascii_r <= 1'b0;
      escaped_any_r    <= 1'b0;
      a_valid_r        <= 1'b0;
      a_phase_r        <= upe_pkg::PH_PCT;
      b_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          upe_pkg::REG_CATEGORY_MASK: cfg_r.category_mask       <= cfg_wdata;
          upe_pkg::REG_FORCE_PERCENT: cfg_r.force_percent       <= cfg_wdata[0];
          upe_pkg::REG_ASCII_ONLY:    cfg_r.ascii_only_mode     <= cfg_wdata[0];
          upe_pkg::REG_NON_ASCII:     cfg_r.non_ascii_only_mode <= cfg_wdata[0];
          upe_pkg::REG_ALWAYS_COPY:   cfg_r.always_copy         <= cfg_wdata[0];
          upe_pkg::REG_ESCAPE_COLON:  cfg_r.escape_colon        <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (acc) begin
        prev_non_ascii_r <= !in_ch.part_last && in_ch.in_byte[upe_pkg::BYTE_W-1];
        escaped_any_r    <= !in_ch.part_last && (escaped_any_r || esc);
      end
      if (acc) begin
        a_valid_r <= 1'b1;
        a_phase_r <= upe_pkg::PH_PCT;
      end else if (a_adv) begin
        if (a_final) begin
          a_valid_r <= 1'b0;
        end
        a_phase_r <= a_phase_r + 2'd1;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      a_byte_r <= in_ch.in_byte;
      a_esc_r  <= esc;
      a_last_r <= in_ch.part_last;
      a_rw_r   <= in_ch.part_last && (escaped_any_r || esc || cfg_r.always_copy);
    end
    if (b_load) begin
      b_byte_r      <= a_out_byte;
      b_run_last_r  <= a_final;
      b_part_end_r  <= a_final && a_last_r;
      b_rewritten_r <= a_final && a_rw_r;
    end
  end

  assign out_ch.valid     = b_valid_r;
  assign out_ch.out_byte  = b_byte_r;
  assign out_ch.run_last  = b_run_last_r;
  assign out_ch.part_end  = b_part_end_r;
  assign out_ch.rewritten = b_rewritten_r;

endmodule
`default_nettype wire
